// File: hdl/wgp_pkg.sv
package wgp_pkg;

  // Sizing of the stores
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int MAX_STEPS  = 16;
  localparam int MAX_RADIUS = 3;

  localparam int KSIDE  = 2 * MAX_RADIUS + 1;
  localparam int KDEPTH = KSIDE * KSIDE;

  localparam int X_W  = $clog2(MAX_WIDTH);
  localparam int Y_W  = $clog2(MAX_HEIGHT);
  localparam int T_W  = $clog2(MAX_STEPS);
  localparam int FA_W = T_W + Y_W + X_W;
  localparam int KA_W = $clog2(KDEPTH);

  // Field and register widths
  localparam int CMD_W      = 3;
  localparam int POS_W      = 6;
  localparam int FI_W       = 4;
  localparam int VAL_W      = 32;
  localparam int GW_W       = 7;
  localparam int GH_W       = 7;
  localparam int KR_W       = 2;
  localparam int ST_W       = 5;
  localparam int KI_W       = KR_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  // Q2.30 arithmetic
  localparam int Q_FRAC = 30;
  localparam int PROD_W = 2 * VAL_W;
  localparam int TERM_W = PROD_W - Q_FRAC;
  localparam int ACC_W  = TERM_W + KA_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = CMD_W'(0),
    CMD_KERNEL = CMD_W'(1),
    CMD_START  = CMD_W'(2),
    CMD_RUN    = CMD_W'(3),
    CMD_READ   = CMD_W'(4)
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH    = CFG_IDX_W'(0),
    REG_GRID_HEIGHT   = CFG_IDX_W'(1),
    REG_KERNEL_RADIUS = CFG_IDX_W'(2),
    REG_STEP_COUNT    = CFG_IDX_W'(3)
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_CLEAR,
    ST_RUN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [GW_W-1:0] grid_width;
    logic [GH_W-1:0] grid_height;
    logic [KR_W-1:0] kernel_radius;
    logic [ST_W-1:0] step_count;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic clear_init;
    logic run_init;
    logic tap_go;
    logic clr_step;
    logic reply_imm;
    logic reply_end;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic run_empty;
    logic frame_end;
    logic pipe_busy;
    logic frames_done;
    logic clr_last;
  } dp_stat_t;

endpackage

// File: hdl/wgp_ctrl.sv
module wgp_ctrl
  import wgp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [CMD_W-1:0] cmd,
  input  dp_stat_t         stat,
  output logic             busy,
  output ctl_t             ctl
);

  state_t state;
  state_t state_next;
  logic   accept;

  // State register; reset starts the store clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign accept = (state == ST_IDLE) && start;
  assign busy   = (state != ST_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cmd == CMD_CLEAR) begin
            state_next = ST_CLEAR;
          end else if (cmd == CMD_RUN && !stat.run_empty) begin
            state_next = ST_RUN;
          end
        end
      end
      ST_INIT, ST_CLEAR: begin
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_RUN: begin
        if (stat.frame_end) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) state_next = stat.frames_done ? ST_IDLE : ST_RUN;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    ctl            = '0;
    ctl.accept     = accept;
    ctl.clear_init = accept && (cmd == CMD_CLEAR);
    ctl.run_init   = accept && (cmd == CMD_RUN);
    ctl.tap_go     = (state == ST_RUN);
    ctl.clr_step   = (state == ST_INIT) || (state == ST_CLEAR);
    ctl.reply_imm  = accept && (cmd != CMD_CLEAR) &&
                     !((cmd == CMD_RUN) && !stat.run_empty);
    ctl.reply_end  = ((state == ST_CLEAR) && stat.clr_last) ||
                     ((state == ST_DRAIN) && !stat.pipe_busy && stat.frames_done);
  end

`ifndef SYNTHESIS
  // No tap may be in flight once the block reports idle
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !stat.pipe_busy)
    else $error("tap pipeline busy while idle");

  // Every reply leaves the block ready for the next word
  a_reply_to_idle: assert property (@(posedge clk) disable iff (rst)
    (ctl.reply_imm || ctl.reply_end) |=> (state == ST_IDLE))
    else $error("reply not followed by idle");

  // At most one reply source per cycle
  a_one_reply: assert property (@(posedge clk) disable iff (rst)
    !(ctl.reply_imm && ctl.reply_end))
    else $error("two replies in one cycle");
`endif

endmodule

// File: hdl/wgp_datapath.sv
module wgp_datapath
  import wgp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  ctl_t             ctl,
  input  logic [CMD_W-1:0] cmd,
  input  logic [POS_W-1:0] pos_x,
  input  logic [POS_W-1:0] pos_y,
  input  logic [FI_W-1:0]  frame_index,
  input  logic [VAL_W-1:0] value,
  output dp_stat_t         stat,
  output logic             done,
  output logic [VAL_W-1:0] read_value,
  output logic             status,
  output logic             saturated
);

  // Effective configuration
  logic [GW_W-1:0] eff_w;
  logic [GH_W-1:0] eff_h;
  logic [KR_W-1:0] eff_r;
  logic [ST_W-1:0] eff_t;
  logic [KI_W-1:0] side;

  assign eff_w = (32'(cfg.grid_width) > MAX_WIDTH) ? GW_W'(MAX_WIDTH) : cfg.grid_width;
  assign eff_h = (32'(cfg.grid_height) > MAX_HEIGHT) ? GH_W'(MAX_HEIGHT) : cfg.grid_height;
  assign eff_r = (32'(cfg.kernel_radius) > MAX_RADIUS) ? KR_W'(MAX_RADIUS)
                                                       : cfg.kernel_radius;
  assign eff_t = (32'(cfg.step_count) > MAX_STEPS) ? ST_W'(MAX_STEPS) : cfg.step_count;
  assign side  = {eff_r, 1'b1};

  // Range checks for single-word commands
  logic kern_ok;
  logic cell_ok;
  logic read_ok;
  logic imm_status;

  assign kern_ok = (32'(pos_x) < 32'(side)) && (32'(pos_y) < 32'(side));
  assign cell_ok = (32'(pos_x) < 32'(eff_w)) && (32'(pos_y) < 32'(eff_h));
  assign read_ok = cell_ok && (32'(frame_index) < 32'(eff_t));

  always_comb begin
    unique case (cmd) inside
      CMD_CLEAR, CMD_RUN: imm_status = 1'b0;
      CMD_KERNEL:         imm_status = !kern_ok;
      CMD_START:          imm_status = !cell_ok;
      CMD_READ:           imm_status = !read_ok;
      default:            imm_status = 1'b1;
    endcase
  end

  // Run loop counters
  logic [ST_W-1:0] t_cnt;
  logic [Y_W-1:0]  y_cnt;
  logic [X_W-1:0]  x_cnt;
  logic [KI_W-1:0] ky;
  logic [KI_W-1:0] kx;
  logic            kx_last;
  logic            ky_last;
  logic            x_last;
  logic            y_last;
  logic            cell_last;

  assign kx_last   = (kx == side - KI_W'(1));
  assign ky_last   = (ky == side - KI_W'(1));
  assign x_last    = (32'(x_cnt) + 32'd1 == 32'(eff_w));
  assign y_last    = (32'(y_cnt) + 32'd1 == 32'(eff_h));
  assign cell_last = kx_last && ky_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_cnt <= '0;
      y_cnt <= '0;
      x_cnt <= '0;
      ky    <= '0;
      kx    <= '0;
    end else if (ctl.run_init) begin
      t_cnt <= ST_W'(1);
      y_cnt <= '0;
      x_cnt <= '0;
      ky    <= '0;
      kx    <= '0;
    end else if (ctl.tap_go) begin
      if (!kx_last) begin
        kx <= kx + KI_W'(1);
      end else begin
        kx <= '0;
        if (!ky_last) begin
          ky <= ky + KI_W'(1);
        end else begin
          ky <= '0;
          if (!x_last) begin
            x_cnt <= x_cnt + X_W'(1);
          end else begin
            x_cnt <= '0;
            if (!y_last) begin
              y_cnt <= y_cnt + Y_W'(1);
            end else begin
              y_cnt <= '0;
              t_cnt <= t_cnt + ST_W'(1);
            end
          end
        end
      end
    end
  end

  // Neighbor of the current tap in the previous frame
  logic [X_W:0] nx_sum;
  logic [X_W:0] nx;
  logic [Y_W:0] ny_sum;
  logic [Y_W:0] ny;
  logic         tap_inb;

  assign nx_sum  = (X_W+1)'(x_cnt) + (X_W+1)'(kx);
  assign nx      = nx_sum - (X_W+1)'(eff_r);
  assign ny_sum  = (Y_W+1)'(y_cnt) + (Y_W+1)'(ky);
  assign ny      = ny_sum - (Y_W+1)'(eff_r);
  assign tap_inb = (nx_sum >= (X_W+1)'(eff_r)) && (32'(nx) < 32'(eff_w)) &&
                   (ny_sum >= (Y_W+1)'(eff_r)) && (32'(ny) < 32'(eff_h));

  // Frame store ports
  logic [FA_W-1:0]  fra;
  logic [FA_W-1:0]  fwa;
  logic [VAL_W-1:0] fwd;
  logic             fwe;
  logic [VAL_W-1:0] frame_q;
  logic [FA_W-1:0]  clr_addr;

  // Tap pipeline registers
  logic             p1_valid;
  logic             p1_inb;
  logic             p1_first;
  logic             p1_last;
  logic [FA_W-1:0]  p1_dest;
  logic             p2_valid;
  logic             p2_first;
  logic             p2_last;
  logic [FA_W-1:0]  p2_dest;
  logic [PROD_W-1:0] p2_prod;
  logic             p3_wr;
  logic [FA_W-1:0]  p3_dest;
  logic [ACC_W-1:0] acc;
  logic             acc_over;

  assign acc_over = |acc[ACC_W-1:VAL_W];

  // Read address: run taps, else the read command
  always_comb begin
    if (ctl.tap_go) begin
      fra = {T_W'(t_cnt - ST_W'(1)), Y_W'(ny), X_W'(nx)};
    end else begin
      fra = {T_W'(frame_index), Y_W'(pos_y), X_W'(pos_x)};
    end
  end

  // Write port: clearing sweep, run results, start cells
  always_comb begin
    fwe = 1'b0;
    fwa = {T_W'(0), Y_W'(pos_y), X_W'(pos_x)};
    fwd = value;
    if (ctl.clr_step) begin
      fwe = 1'b1;
      fwa = clr_addr;
      fwd = '0;
    end else if (p3_wr) begin
      fwe = 1'b1;
      fwa = p3_dest;
      fwd = acc_over ? '1 : acc[VAL_W-1:0];
    end else if (ctl.accept && (cmd == CMD_START) && cell_ok) begin
      fwe = 1'b1;
    end
  end

  logic [VAL_W-1:0] fmem [2**FA_W];

  always_ff @(posedge clk) begin
    if (fwe) fmem[fwa] <= fwd;
    frame_q <= fmem[fra];
  end

  // Clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctl.clr_step) begin
      clr_addr <= clr_addr + FA_W'(1);
    end
  end

  // Kernel store with per-entry valid bits
  logic [KA_W-1:0]  ka_wr;
  logic [KA_W-1:0]  ka_rd;
  logic             kwe;
  logic [VAL_W-1:0] kmem [KDEPTH];
  logic [KDEPTH-1:0] kvalid;
  logic [VAL_W-1:0] kern_q;
  logic             kv_q;

  assign ka_wr = KA_W'(32'(pos_y) * KSIDE + 32'(pos_x));
  assign ka_rd = KA_W'(32'(ky) * KSIDE + 32'(kx));
  assign kwe   = ctl.accept && (cmd == CMD_KERNEL) && kern_ok;

  always_ff @(posedge clk) begin
    if (kwe) kmem[ka_wr] <= value;
    kern_q <= kmem[ka_rd];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kvalid <= '0;
      kv_q   <= 1'b0;
    end else begin
      if (kwe) kvalid[ka_wr] <= 1'b1;
      kv_q <= kvalid[ka_rd];
    end
  end

  // Tap pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_wr    <= 1'b0;
    end else begin
      p1_valid <= ctl.tap_go;
      p2_valid <= p1_valid;
      p3_wr    <= p2_valid && p2_last;
    end
  end

  // Tap pipeline payload: address, multiply, accumulate
  always_ff @(posedge clk) begin
    p1_inb   <= tap_inb;
    p1_first <= (kx == '0) && (ky == '0);
    p1_last  <= cell_last;
    p1_dest  <= {T_W'(t_cnt), Y_W'(y_cnt), X_W'(x_cnt)};
    p2_first <= p1_first;
    p2_last  <= p1_last;
    p2_dest  <= p1_dest;
    p2_prod  <= (p1_inb && kv_q) ? PROD_W'(frame_q) * PROD_W'(kern_q) : '0;
    p3_dest  <= p2_dest;
    if (p2_valid) begin
      acc <= (p2_first ? '0 : acc) + ACC_W'(p2_prod[PROD_W-1:Q_FRAC]);
    end
  end

  // Saturation flag
  logic sat_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      sat_flag <= 1'b0;
    end else if (ctl.clear_init || ctl.run_init) begin
      sat_flag <= 1'b0;
    end else if (p3_wr && acc_over) begin
      sat_flag <= 1'b1;
    end
  end

  // Result word
  logic done_q;
  logic status_q;
  logic rd_ok_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      done_q   <= 1'b0;
      status_q <= 1'b0;
      rd_ok_q  <= 1'b0;
    end else begin
      done_q   <= ctl.reply_imm || ctl.reply_end;
      status_q <= ctl.reply_imm && imm_status;
      rd_ok_q  <= ctl.reply_imm && (cmd == CMD_READ) && read_ok;
    end
  end

  assign done       = done_q;
  assign status     = status_q;
  assign read_value = rd_ok_q ? frame_q : '0;
  assign saturated  = sat_flag;

  // Status to the controller
  always_comb begin
    stat             = '0;
    stat.run_empty   = (32'(eff_t) <= 32'd1) || (eff_w == '0) || (eff_h == '0);
    stat.frame_end   = cell_last && x_last && y_last;
    stat.pipe_busy   = p1_valid || p2_valid || p3_wr;
    stat.frames_done = (32'(t_cnt) >= 32'(eff_t));
    stat.clr_last    = &clr_addr;
  end

`ifndef SYNTHESIS
  // The clearing sweep owns the write port alone
  a_wport_excl: assert property (@(posedge clk) disable iff (rst)
    p3_wr |-> !ctl.clr_step)
    else $error("run write during clearing sweep");

  // A tap never reads the cell being written back
  a_no_hazard: assert property (@(posedge clk) disable iff (rst)
    (ctl.tap_go && p3_wr) |-> (fra != p3_dest))
    else $error("tap read hits pending write");

  // Taps only run on frames 1 to T-1
  a_frame_range: assert property (@(posedge clk) disable iff (rst)
    ctl.tap_go |-> ((t_cnt != '0) && (32'(t_cnt) < 32'(eff_t))))
    else $error("tap outside frame range");
`endif

endmodule

// File: hdl/walk_grid_propagation_core.sv
// Channel   Handshake               Payload
// command   start in, busy out      cmd, pos_x, pos_y, frame_index, value
// result    done out (one cycle)    read_value, status, saturated
// config    cfg_valid, cfg_ready    cfg_index, cfg_data
//
// Kernel write, start write, read and unknown commands leave busy low: the
// result word follows in the cycle after start, and a new word is taken every cycle.
// Run: one kernel tap per cycle, paused while the tap pipeline drains after each frame,
// through the single multiplier and the frame store read port.
// Clear command and reset: a sweep that zeroes all 65536 words of the frame store, busy high.
// done is a one-cycle pulse; the receiver cannot stall it.
module walk_grid_propagation_core
  import wgp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [CMD_W-1:0]      cmd,
  input  logic [POS_W-1:0]      pos_x,
  input  logic [POS_W-1:0]      pos_y,
  input  logic [FI_W-1:0]       frame_index,
  input  logic [VAL_W-1:0]      value,
  output logic                  done,
  output logic [VAL_W-1:0]      read_value,
  output logic                  status,
  output logic                  saturated,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t     cfg;
  ctl_t     ctl;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_width    <= GW_W'(64);
      cfg.grid_height   <= GH_W'(64);
      cfg.kernel_radius <= KR_W'(1);
      cfg.step_count    <= ST_W'(16);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GRID_WIDTH:    cfg.grid_width    <= cfg_data[GW_W-1:0];
        REG_GRID_HEIGHT:   cfg.grid_height   <= cfg_data[GH_W-1:0];
        REG_KERNEL_RADIUS: cfg.kernel_radius <= cfg_data[KR_W-1:0];
        REG_STEP_COUNT:    cfg.step_count    <= cfg_data[ST_W-1:0];
        default: ;
      endcase
    end
  end

  wgp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .stat  (stat),
    .busy  (busy),
    .ctl   (ctl)
  );

  wgp_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .ctl         (ctl),
    .cmd         (cmd),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .frame_index (frame_index),
    .value       (value),
    .stat        (stat),
    .done        (done),
    .read_value  (read_value),
    .status      (status),
    .saturated   (saturated)
  );

endmodule

// File: bench/tb_walk_grid_propagation_core.sv
module tb_walk_grid_propagation_core
  import wgp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int GAP_PCT = 7;
  localparam int RUN_BUDGET = 3000;
  localparam longint unsigned Q_TOP = 64'hFFFF_FFFF;
  localparam logic STS_OK = 1'b0;
  localparam logic STS_REFUSED = 1'b1;

  typedef struct {
    logic [CMD_W-1:0] op;
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
    logic [FI_W-1:0]  fi;
    logic [VAL_W-1:0] val;
    bit               drain;
    bit               steady;
  } cmd_word_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             status;
    logic             saturated;
  } reply_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [CMD_W-1:0]      cmd = '0;
  logic [POS_W-1:0]      pos_x = '0;
  logic [POS_W-1:0]      pos_y = '0;
  logic [FI_W-1:0]       frame_index = '0;
  logic [VAL_W-1:0]      value = '0;
  logic                  done;
  logic [VAL_W-1:0]      read_value;
  logic                  status;
  logic                  saturated;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  walk_grid_propagation_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .frame_index (frame_index),
    .value       (value),
    .done        (done),
    .read_value  (read_value),
    .status      (status),
    .saturated   (saturated),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  cmd_word_t cmd_fifo[$];
  reply_t    replies_due[$];
  int        fail_count = 0;
  int        issued = 0;
  int        clears_left = 3;
  bit        calm = 1'b0;

  // Shadow of the grid engine: frames, kernel, flag and register values
  bit [VAL_W-1:0]   frames [MAX_STEPS * MAX_HEIGHT * MAX_WIDTH];
  bit [VAL_W-1:0]   kern [KDEPTH];
  bit               sat_now;
  logic [GW_W-1:0]  reg_width = GW_W'(64);
  logic [GH_W-1:0]  reg_height = GH_W'(64);
  logic [KR_W-1:0]  reg_radius = KR_W'(1);
  logic [ST_W-1:0]  reg_steps = ST_W'(16);

  function automatic int cell_index(int f, int x, int y);
    return (f * MAX_HEIGHT + y) * MAX_WIDTH + x;
  endfunction

  // Register values clipped to the store sizes
  function automatic void grid_dims(output int w, output int h, output int r, output int t);
    w = (reg_width > MAX_WIDTH) ? MAX_WIDTH : int'(reg_width);
    h = (reg_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(reg_height);
    r = (reg_radius > MAX_RADIUS) ? MAX_RADIUS : int'(reg_radius);
    t = (reg_steps > MAX_STEPS) ? MAX_STEPS : int'(reg_steps);
  endfunction

  // Convolve frame f-1 into frame f over the region in use
  function automatic void advance_frames();
    int w, h, r, t, nx, ny;
    longint unsigned acc, a, k;
    grid_dims(w, h, r, t);
    sat_now = 1'b0;
    for (int f = 1; f < t; f++) begin
      for (int y = 0; y < h; y++) begin
        for (int x = 0; x < w; x++) begin
          acc = 0;
          for (int dy = -r; dy <= r; dy++) begin
            ny = y + dy;
            if (ny >= 0 && ny < h) begin
              for (int dx = -r; dx <= r; dx++) begin
                nx = x + dx;
                if (nx >= 0 && nx < w) begin
                  a = frames[cell_index(f - 1, nx, ny)];
                  k = kern[(dy + r) * KSIDE + dx + r];
                  acc += (a * k) >> Q_FRAC;
                end
              end
            end
          end
          if (acc > Q_TOP) begin
            acc = Q_TOP;
            sat_now = 1'b1;
          end
          frames[cell_index(f, x, y)] = VAL_W'(acc);
        end
      end
    end
  endfunction

  // Apply one command word to the shadow and return its reply
  function automatic reply_t apply_command(logic [CMD_W-1:0] op, logic [POS_W-1:0] px,
                                           logic [POS_W-1:0] py, logic [FI_W-1:0] fi,
                                           logic [VAL_W-1:0] val);
    reply_t rep;
    int w, h, r, t;
    grid_dims(w, h, r, t);
    rep.value = '0;
    rep.status = STS_OK;
    case (op)
      CMD_CLEAR: begin
        foreach (frames[i]) frames[i] = '0;
        sat_now = 1'b0;
      end
      CMD_KERNEL: begin
        if (px < 2 * r + 1 && py < 2 * r + 1) kern[py * KSIDE + px] = val;
        else rep.status = STS_REFUSED;
      end
      CMD_START: begin
        if (px < w && py < h) frames[cell_index(0, px, py)] = val;
        else rep.status = STS_REFUSED;
      end
      CMD_RUN: advance_frames();
      CMD_READ: begin
        if (fi < t && px < w && py < h) rep.value = frames[cell_index(fi, px, py)];
        else rep.status = STS_REFUSED;
      end
      default: rep.status = STS_REFUSED;
    endcase
    rep.saturated = sat_now;
    return rep;
  endfunction

  // Driver: present the head word at the falling edge, with random gaps
  always @(negedge clk) begin
    if (rst || cmd_fifo.size() == 0) begin
      start <= 1'b0;
    end else if (cmd_fifo[0].drain && replies_due.size() != 0) begin
      start <= 1'b0;
    end else if (!cmd_fifo[0].steady && $urandom_range(0, 99) < GAP_PCT) begin
      start <= 1'b0;
    end else begin
      start <= 1'b1;
      cmd <= cmd_fifo[0].op;
      pos_x <= cmd_fifo[0].px;
      pos_y <= cmd_fifo[0].py;
      frame_index <= cmd_fifo[0].fi;
      value <= cmd_fifo[0].val;
    end
  end

  // Monitor: check result words, then log the word taken at this edge
  always @(posedge clk) begin : check_replies
    reply_t want;
    if (!rst && done) begin
      if (replies_due.size() == 0) begin
        $error("result word with none pending: read_value %h status %b", read_value, status);
        fail_count++;
      end else begin
        want = replies_due.pop_front();
        if (read_value !== want.value) begin
          $error("read_value expected %h actual %h", want.value, read_value);
          fail_count++;
        end
        if (status !== want.status) begin
          $error("status expected %b actual %b", want.status, status);
          fail_count++;
        end
        if (saturated !== want.saturated) begin
          $error("saturated expected %b actual %b", want.saturated, saturated);
          fail_count++;
        end
      end
    end
    if (!rst && start && !busy) begin
      replies_due.push_back(apply_command(cmd, pos_x, pos_y, frame_index, value));
      void'(cmd_fifo.pop_front());
    end
  end

  task automatic queue_word(int op, int px, int py, int fi, logic [VAL_W-1:0] val, bit drain);
    cmd_word_t cw;
    cw.op = CMD_W'(op);
    cw.px = POS_W'(px);
    cw.py = POS_W'(py);
    cw.fi = FI_W'(fi);
    cw.val = val;
    cw.drain = drain;
    cw.steady = calm;
    cmd_fifo.push_back(cw);
    issued++;
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (cmd_fifo.size() != 0 || replies_due.size() != 0 || busy) @(posedge clk);
  endtask

  // One register write; valid stays up for the caller to lower or reuse
  task automatic write_reg(int idx, int data);
    logic [CFG_IDX_W-1:0]  slot;
    logic [CFG_DATA_W-1:0] bits;
    slot = CFG_IDX_W'(idx);
    bits = CFG_DATA_W'(data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= slot;
    cfg_data <= bits;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (slot)
      REG_GRID_WIDTH:    reg_width = bits;
      REG_GRID_HEIGHT:   reg_height = bits;
      REG_KERNEL_RADIUS: reg_radius = bits[KR_W-1:0];
      REG_STEP_COUNT:    reg_steps = bits[ST_W-1:0];
      default: ;
    endcase
  endtask

  // Reprogram all four registers once the engine has gone quiet
  task automatic set_grid(int w, int h, int r, int t);
    wait_idle();
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
    write_reg(REG_KERNEL_RADIUS, ($urandom_range(0, 31) << KR_W) | r);
    write_reg(REG_STEP_COUNT, ($urandom_range(0, 3) << ST_W) | t);
    // index past the register list, must be ignored
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(REG_STEP_COUNT + 1, (1 << CFG_IDX_W) - 1), $urandom_range(0, 127));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_extent();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return 0;
    if (roll < 20) return 1;
    if (roll < 35) return $urandom_range(64, 127);
    return $urandom_range(2, 8);
  endfunction

  function automatic logic [VAL_W-1:0] pick_weight();
    if ($urandom_range(0, 99) < 15) return $urandom();
    return $urandom_range(0, 32'h2000_0000);
  endfunction

  function automatic logic [VAL_W-1:0] pick_cell();
    if ($urandom_range(0, 99) < 15) return $urandom();
    return $urandom_range(0, 32'h4000_0000);
  endfunction

  // Kernel load, start grid, run, read back frames; a little noise at the end
  task automatic fill_episode();
    int w, h, r, t, side, op;
    grid_dims(w, h, r, t);
    side = 2 * r + 1;
    repeat ($urandom_range(1, side * side + 2)) begin
      if ($urandom_range(0, 9) != 0)
        queue_word(CMD_KERNEL, $urandom_range(0, side - 1), $urandom_range(0, side - 1),
                   $urandom_range(0, 15), pick_weight(), 1'b0);
      else
        queue_word(CMD_KERNEL, $urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 15), pick_weight(), 1'b0);
    end
    repeat ($urandom_range(1, 2)) begin
      repeat ($urandom_range(1, 10)) begin
        if (w > 0 && h > 0 && $urandom_range(0, 9) != 0)
          queue_word(CMD_START, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                     $urandom_range(0, 15), pick_cell(), 1'b0);
        else
          queue_word(CMD_START, $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 15), pick_cell(), 1'b0);
      end
      queue_word(CMD_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
                 $urandom_range(0, 15), $urandom(), 1'b0);
      for (int i = $urandom_range(4, 12); i > 0; i--) begin
        if (t > 0 && w > 0 && h > 0 && $urandom_range(0, 6) != 0)
          queue_word(CMD_READ, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                     $urandom_range(0, t - 1), $urandom(), i == 1 && $urandom_range(0, 1));
        else
          queue_word(CMD_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 15), $urandom(), 1'b0);
      end
    end
    repeat ($urandom_range(0, 2)) begin
      op = $urandom_range(0, 7);
      // a clear costs a full store sweep, so only a few get through
      if (op == CMD_CLEAR) begin
        if (clears_left > 0) clears_left--;
        else op = CMD_READ;
      end
      queue_word(op, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 15),
                 $urandom(), 1'b0);
    end
  endtask

  // Stimulus sequence
  initial begin
    int ep, w, h, r, t, ew, eh, er, et, cost;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // reset settings: loads, refused writes, reads, unknown commands, clear
    queue_word(CMD_KERNEL, 0, 0, 0, 32'hFFFF_FFFF, 1'b0);
    queue_word(CMD_KERNEL, 2, 2, 15, 32'h4000_0000, 1'b0);
    queue_word(CMD_KERNEL, 3, 1, 0, 32'h1234_5678, 1'b0);
    queue_word(CMD_KERNEL, 1, 63, 0, 32'h1234_5678, 1'b0);
    queue_word(CMD_START, 0, 0, 0, 32'hFFFF_FFFF, 1'b0);
    queue_word(CMD_START, 63, 63, 0, 32'h4000_0000, 1'b0);
    queue_word(CMD_READ, 63, 63, 0, 32'h0, 1'b0);
    queue_word(CMD_READ, 63, 63, 15, 32'h0, 1'b0);
    queue_word(CMD_READ + 1, 17, 42, 9, $urandom(), 1'b0);
    queue_word((1 << CMD_W) - 1, 63, 63, 15, 32'hFFFF_FFFF, 1'b0);
    queue_word(CMD_CLEAR, 0, 0, 0, 32'h0, 1'b0);
    queue_word(CMD_READ, 0, 0, 0, 32'h0, 1'b1);

    // tiny grid: edges, out of range start and read, saturating run
    set_grid(3, 3, 1, 3);
    queue_word(CMD_KERNEL, 1, 1, 0, 32'h4000_0000, 1'b0);
    queue_word(CMD_KERNEL, 0, 0, 0, 32'h2000_0000, 1'b0);
    queue_word(CMD_START, 2, 2, 0, 32'h8000_0000, 1'b0);
    queue_word(CMD_START, 3, 0, 0, 32'h8000_0000, 1'b0);
    queue_word(CMD_RUN, 0, 0, 0, 32'h0, 1'b0);
    queue_word(CMD_READ, 0, 0, 2, 32'h0, 1'b1);
    queue_word(CMD_READ, 0, 0, 3, 32'h0, 1'b0);
    queue_word(CMD_READ, 0, 3, 1, 32'h0, 1'b0);
    queue_word(CMD_KERNEL, 2, 2, 0, 32'hFFFF_FFFF, 1'b0);
    queue_word(CMD_START, 1, 1, 0, 32'hFFFF_FFFF, 1'b0);
    queue_word(CMD_RUN, 0, 0, 0, 32'h0, 1'b0);
    queue_word(CMD_READ, 1, 1, 1, 32'h0, 1'b0);
    queue_word(CMD_READ + 2, 5, 5, 5, $urandom(), 1'b0);

    // random episodes, the first few on the register extremes
    ep = 0;
    while (issued < 1035) begin
      case (ep)
        0: set_grid(64, 1, 3, 2);
        1: set_grid(1, 64, 0, 16);
        2: set_grid(64, 64, 0, 2);
        3: set_grid(1, 1, 3, 16);
        4: set_grid(0, 5, 2, 4);
        5: set_grid(100, 2, 1, 0);
        6: set_grid(1, 127, 1, 31);
        default: begin
          do begin
            w = pick_extent();
            h = pick_extent();
            r = $urandom_range(0, MAX_RADIUS);
            case ($urandom_range(0, 19))
              0: t = 0;
              1, 2: t = 1;
              3, 4: t = $urandom_range(16, 31);
              default: t = $urandom_range(2, 6);
            endcase
            ew = (w > MAX_WIDTH) ? MAX_WIDTH : w;
            eh = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
            er = 2 * r + 1;
            et = (t > MAX_STEPS) ? MAX_STEPS : t;
            cost = (et <= 1) ? 1 : (et - 1) * (ew * eh * er * er + 4);
          end while (cost > RUN_BUDGET);
          set_grid(w, h, r, t);
        end
      endcase
      calm = (ep >= 8 && ep < 11);
      fill_episode();
      ep++;
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("walk_grid_propagation_core test passed");
    end else begin
      $display("walk_grid_propagation_core test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #60_000_000;
    $display("walk_grid_propagation_core test failed");
    $finish;
  end

endmodule

// File: files.f
hdl/wgp_pkg.sv
hdl/wgp_ctrl.sv
hdl/wgp_datapath.sv
hdl/walk_grid_propagation_core.sv
bench/tb_walk_grid_propagation_core.sv
